[sv/nqsc_pkg.sv]
// shared constants for the n-queens solution counter
// no dependencies; used by every module of the block but nqsc_mask_unit
package nqsc_pkg;

    // default largest board the search stack is sized for
    localparam int MAX_BOARD_DEF = 15;

    // field widths
    localparam int LOW_W   = 4;
    localparam int COL_W   = 5;
    localparam int COUNT_W = 22;
    localparam int SIZE_W  = 4;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // register index decoded from paddr[2]
    localparam logic REG_GRID_SIZE = 1'b0;

    // grid size after reset
    localparam logic [SIZE_W-1:0] GRID_SIZE_RST = 4'd8;

endpackage

[sv/nqsc_apb_regs.sv]
// configuration register file (grid size) behind an apb-style port
// depends on nqsc_pkg
module nqsc_apb_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nqsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nqsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nqsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output logic [nqsc_pkg::SIZE_W-1:0]         grid_size
);

    logic [nqsc_pkg::SIZE_W-1:0] grid_size_reg;
    logic                        hit_grid_size;
    logic                        wr_transfer;

    // address decode and write transfer
    assign hit_grid_size = (paddr[nqsc_pkg::APB_ADDR_W-1] == nqsc_pkg::REG_GRID_SIZE);
    assign wr_transfer   = psel & penable & pwrite & pready;
    assign pready        = 1'b1;

    // grid size register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= nqsc_pkg::GRID_SIZE_RST;
        end
        else if (wr_transfer && hit_grid_size)
        begin
            grid_size_reg <= pwdata[nqsc_pkg::SIZE_W-1:0];
        end
    end

    // read data
    always_comb
    begin
        prdata = '0;
        if (hit_grid_size)
        begin
            prdata[nqsc_pkg::SIZE_W-1:0] = grid_size_reg;
        end
    end

    assign grid_size = grid_size_reg;

endmodule

[sv/nqsc_mask_unit.sv]
// shared attack-mask unit: picks a free column and derives the next row's masks
// depends on nqsc_pkg only through the parameter handed down from the top level
module nqsc_mask_unit
#(
    parameter int MASK_W = 15
)
(
    input  logic [MASK_W-1:0] full,
    input  logic [MASK_W-1:0] col,
    input  logic [MASK_W-1:0] ld,
    input  logic [MASK_W-1:0] rd,
    input  logic [MASK_W-1:0] rem,
    input  logic [MASK_W-1:0] seed_bit,
    input  logic              use_seed,
    output logic              rem_empty,
    output logic [MASK_W-1:0] rem_left,
    output logic [MASK_W-1:0] col_nx,
    output logic [MASK_W-1:0] ld_nx,
    output logic [MASK_W-1:0] rd_nx,
    output logic [MASK_W-1:0] rem_nx
);

    logic [MASK_W-1:0] low_bit;
    logic [MASK_W-1:0] pick;

    // lowest free column of the current row
    assign low_bit   = rem & (~rem + MASK_W'(1));
    assign rem_empty = (rem == '0);
    assign pick      = use_seed ? seed_bit : low_bit;
    assign rem_left  = rem ^ low_bit;

    // masks seen by the next row
    assign col_nx = col | pick;
    assign ld_nx  = ((ld | pick) << 1) & full;
    assign rd_nx  = (rd | pick) >> 1;
    assign rem_nx = full & ~(col_nx | ld_nx | rd_nx);

endmodule

[sv/nqsc_search_seq.sv]
// backtracking sequencer with the per-row mask stack and solution counter
// depends on nqsc_pkg and nqsc_mask_unit
module nqsc_search_seq
#(
    parameter int MAX_BOARD = nqsc_pkg::MAX_BOARD_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [nqsc_pkg::LOW_W-1:0]       first_col_low,
    input  logic [nqsc_pkg::COL_W-1:0]       first_col_high,
    input  logic [nqsc_pkg::SIZE_W-1:0]      grid_size,
    output logic                             busy,
    output logic                             done,
    output logic [nqsc_pkg::COUNT_W-1:0]     solution_count
);

    localparam int MASK_W = MAX_BOARD;
    localparam int DW     = $clog2(MAX_BOARD);
    localparam int COL_W  = nqsc_pkg::COL_W;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ROW    = 4'b0010,
        S_SEARCH = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    state_t                          state_reg, state_next;
    logic [COL_W-1:0]                n_reg, n_next;
    logic [COL_W-1:0]                hi_reg, hi_next;
    logic [COL_W-1:0]                c0_reg, c0_next;
    logic [DW-1:0]                   d_reg, d_next;
    logic [nqsc_pkg::COUNT_W-1:0]    count_reg, count_next;

    // mask stack, one entry per row
    logic [MASK_W-1:0] col_stk [MAX_BOARD];
    logic [MASK_W-1:0] ld_stk  [MAX_BOARD];
    logic [MASK_W-1:0] rd_stk  [MAX_BOARD];
    logic [MASK_W-1:0] rem_stk [MAX_BOARD];

    logic              push_en;
    logic [DW-1:0]     push_idx;
    logic              rem_upd_en;

    logic [COL_W-1:0]  n_clip;
    logic [MASK_W-1:0] full;
    logic [MASK_W-1:0] seed_bit;
    logic              use_seed;
    logic [MASK_W-1:0] u_col, u_ld, u_rd, u_rem;
    logic              rem_empty;
    logic [MASK_W-1:0] rem_left, col_nx, ld_nx, rd_nx, rem_nx;
    logic [COL_W-1:0]  d_ext;

    // grid size clipped to the stack depth
    assign n_clip = ({1'b0, grid_size} > COL_W'(MAX_BOARD)) ? COL_W'(MAX_BOARD)
                                                            : {1'b0, grid_size};

    // all-columns mask of the active board
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            full[i] = (COL_W'(i) < n_reg);
        end
    end

    // shared unit operands: row zero seeds from empty masks
    assign use_seed = (state_reg == S_ROW);
    assign seed_bit = MASK_W'(1) << c0_reg;
    assign u_col    = use_seed ? '0 : col_stk[d_reg];
    assign u_ld     = use_seed ? '0 : ld_stk[d_reg];
    assign u_rd     = use_seed ? '0 : rd_stk[d_reg];
    assign u_rem    = rem_stk[d_reg];
    assign d_ext    = COL_W'(d_reg);

    nqsc_mask_unit
    #(
        .MASK_W (MASK_W)
    )
    u_mask
    (
        .full      (full),
        .col       (u_col),
        .ld        (u_ld),
        .rd        (u_rd),
        .rem       (u_rem),
        .seed_bit  (seed_bit),
        .use_seed  (use_seed),
        .rem_empty (rem_empty),
        .rem_left  (rem_left),
        .col_nx    (col_nx),
        .ld_nx     (ld_nx),
        .rd_nx     (rd_nx),
        .rem_nx    (rem_nx)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        n_next     = n_reg;
        hi_next    = hi_reg;
        c0_next    = c0_reg;
        d_next     = d_reg;
        count_next = count_reg;
        push_en    = 1'b0;
        push_idx   = d_reg + DW'(1);
        rem_upd_en = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    n_next     = n_clip;
                    hi_next    = (first_col_high > n_clip) ? n_clip : first_col_high;
                    c0_next    = {1'b0, first_col_low};
                    count_next = '0;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                if (c0_reg >= hi_reg)
                begin
                    state_next = S_DONE;
                end
                else if (n_reg == COL_W'(1))
                begin
                    count_next = count_reg + nqsc_pkg::COUNT_W'(1);
                    c0_next    = c0_reg + COL_W'(1);
                end
                else
                begin
                    push_en    = 1'b1;
                    push_idx   = DW'(1);
                    d_next     = DW'(1);
                    state_next = S_SEARCH;
                end
            end
            S_SEARCH:
            begin
                if (rem_empty)
                begin
                    if (d_reg == DW'(1))
                    begin
                        c0_next    = c0_reg + COL_W'(1);
                        state_next = S_ROW;
                    end
                    else
                    begin
                        d_next = d_reg - DW'(1);
                    end
                end
                else
                begin
                    rem_upd_en = 1'b1;
                    if (d_ext + COL_W'(1) >= n_reg)
                    begin
                        count_next = count_reg + nqsc_pkg::COUNT_W'(1);
                    end
                    else
                    begin
                        push_en = 1'b1;
                        d_next  = d_reg + DW'(1);
                    end
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            n_reg     <= '0;
            hi_reg    <= '0;
            c0_reg    <= '0;
            d_reg     <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            n_reg     <= n_next;
            hi_reg    <= hi_next;
            c0_reg    <= c0_next;
            d_reg     <= d_next;
            count_reg <= count_next;
        end
    end

    // mask stack writes: push next row, consume a column of the current row
    always_ff @(posedge clk)
    begin
        if (push_en)
        begin
            col_stk[push_idx] <= col_nx;
            ld_stk[push_idx]  <= ld_nx;
            rd_stk[push_idx]  <= rd_nx;
            rem_stk[push_idx] <= rem_nx;
        end
        if (rem_upd_en)
        begin
            rem_stk[d_reg] <= rem_left;
        end
    end

    // result strobe and status
    assign busy           = (state_reg != S_IDLE);
    assign done           = (state_reg == S_DONE);
    assign solution_count = count_reg;

endmodule

[sv/nqueens_solution_counter_top.sv]
// n-queens solution counter, top level
// instantiates nqsc_apb_regs and nqsc_search_seq; depends on nqsc_pkg
//
// usage:
//   set the grid size (register 0, byte address 0, reset 8) over the apb port
//   while the block is idle. pready is always high; reads return the value.
//   start an item by raising start while busy is low; the transfer takes
//   first_col_low (inclusive) and first_col_high (exclusive, clipped to the
//   board size) as the range of the row-zero queen.
//   busy stays high until the count is delivered. done is high for exactly
//   one cycle with solution_count valid; the receiver cannot stall it.
// operation:
//   one search step of the shared mask unit per cycle: a step tries a
//   column or backtracks one row, and each row-zero column is a step of
//   its own. The block takes one item at a time.
// reset:
//   rst_n clears the sequencer to idle and sets the grid size to 8; the mask
//   stack needs no clearing since every row is written before it is read.
module nqueens_solution_counter_top
#(
    parameter int MAX_BOARD = nqsc_pkg::MAX_BOARD_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [nqsc_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [nqsc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [nqsc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                start,
    output logic                                busy,
    input  logic [nqsc_pkg::LOW_W-1:0]          first_col_low,
    input  logic [nqsc_pkg::COL_W-1:0]          first_col_high,
    output logic                                done,
    output logic [nqsc_pkg::COUNT_W-1:0]        solution_count
);

    logic [nqsc_pkg::SIZE_W-1:0] grid_size;

    // configuration registers
    nqsc_apb_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .grid_size (grid_size)
    );

    // backtracking search
    nqsc_search_seq
    #(
        .MAX_BOARD (MAX_BOARD)
    )
    u_search
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .first_col_low  (first_col_low),
        .first_col_high (first_col_high),
        .grid_size      (grid_size),
        .busy           (busy),
        .done           (done),
        .solution_count (solution_count)
    );

endmodule
